### hdl/tile_grout_height_sampler_defines.svh
// Assertion macros shared by the tile grout height sampler RTL.
`ifndef TILE_GROUT_HEIGHT_SAMPLER_DEFINES_SVH
`define TILE_GROUT_HEIGHT_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define TGH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tgh check failed");
`define TGH_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tgh forbidden condition");
`else
`define TGH_ASSERT(lbl, prop)
`define TGH_ASSERT_NEVER(lbl, cond)
`endif
`endif

### hdl/tgh_pkg.sv
// Shared constants and types of the tile grout height sampler.
package tgh_pkg;

  localparam int GRID_SIDE   = 16;
  localparam int IDX_W       = $clog2(GRID_SIDE);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int GRID_DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int KIND_BITS   = 4;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int LEN_W       = 24;
  localparam int CELL_W      = LEN_W + 2;
  localparam int PAT_W       = CELL_W + IDX_W;
  localparam int SIDE_W      = IDX_W + 1;
  localparam int HEIGHT_W    = FRAC_BITS + 1;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 24;
  localparam int WRAP_LAT    = COORD_W + IDX_W + 2;
  localparam int BEVEL_LAT   = FRAC_BITS + 4;

  localparam logic [HEIGHT_W-1:0] ONE_Q16 = HEIGHT_W'(1) << FRAC_BITS;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    REG_TILE_WIDTH  = 2'd0,
    REG_GROUT_WIDTH = 2'd1,
    REG_GRID_SIZE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 wr;
    logic [ADDR_W-1:0]    waddr;
    logic [KIND_BITS-1:0] wkind;
    logic [ADDR_W-1:0]    raddr_own;
    logic [ADDR_W-1:0]    raddr_nb;
  } grid_req_t;

endpackage

### hdl/tile_grout_height_sampler.sv
// Top level of the tile grout height sampler.
`include "tile_grout_height_sampler_defines.svh"

// Takes one request per clock, sample or grid write, and returns one result per
// sample; writes return nothing. The pipeline is formed chiefly
// by the 32-step remainder chain that wraps each coordinate over the pattern,
// followed by a 4-step cell index divide and a 16-step grout ramp divide, all
// fully pipelined. Behind the result register sits a one-entry skid, so the
// input keeps flowing while one result waits; the whole pipeline holds only
// when the skid is occupied. The tile type grid (16 x 16 entries, 4 bits) is
// a RAM with per-entry valid bits, so it reads as all zero right after reset
// with no clearing pass. Grid writes and grid reads happen at the same stage
// in request order, so a sample always sees every earlier write and no later
// one. Configuration is taken at any time and must only change while idle.
module tile_grout_height_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // coord_u[31:0], coord_v[63:32], cell_column[67:64], cell_row[71:68],
  // tile_kind[75:72], zero fill [79:76]
  input  logic [tgh_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode[0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // height[16:0], on_grout[17], zero fill [23:18]
  output logic [tgh_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [tgh_pkg::LEN_W-1:0]         cfg_data
);
  import tgh_pkg::*;

  // configuration
  logic [LEN_W-1:0]  tw_r;
  logic [LEN_W-1:0]  gw_r;
  logic [SIDE_W-1:0] gs_r;
  logic [SIDE_W-1:0] side_c;
  logic [CELL_W-1:0] cell_c;
  logic [SIDE_W-1:0] side_r;
  logic [CELL_W-1:0] cell_r;
  logic [PAT_W-1:0]  pat_r;
  logic [IDX_W-1:0]  side_m1;

  // pipeline control and sideband
  logic                 en;
  logic                 sb_vld_r  [0:WRAP_LAT-1];
  logic                 sb_op_r   [0:WRAP_LAT-1];
  logic [ADDR_W-1:0]    sb_waddr_r[0:WRAP_LAT-1];
  logic [KIND_BITS-1:0] sb_kind_r [0:WRAP_LAT-1];
  logic                 md_vld_r  [0:BEVEL_LAT-1];
  logic                 md_smp_r  [0:BEVEL_LAT-1];
  logic                 mix_r     [1:BEVEL_LAT-1];
  logic                 edge_r;

  // datapath
  logic [IDX_W-1:0]     idx_u;
  logic [IDX_W-1:0]     idx_v;
  logic [CELL_W-1:0]    pos_u;
  logic [CELL_W-1:0]    pos_v;
  logic [CELL_W-1:0]    hi_edge;
  logic                 lo_u;
  logic                 hi_u;
  logic                 lo_v;
  logic                 hi_v;
  logic [IDX_W-1:0]     nb_u;
  logic [IDX_W-1:0]     nb_v;
  grid_req_t            greq;
  logic [KIND_BITS-1:0] own_kind;
  logic [KIND_BITS-1:0] nb_kind;
  logic [HEIGHT_W-1:0]  bevel_u;
  logic [HEIGHT_W-1:0]  bevel_v;
  logic [2*HEIGHT_W-1:0] hprod;
  logic                 res_vld;
  logic                 res_mix;
  logic [HEIGHT_W-1:0]  res_height;
  logic [OUT_DATA_W-1:0] res_data;

  // output register and skid
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  skid_valid_r;
  logic [OUT_DATA_W-1:0] skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= LEN_W'(65536);
      gw_r <= LEN_W'(4096);
      gs_r <= SIDE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:  tw_r <= cfg_data;
        REG_GROUT_WIDTH: gw_r <= cfg_data;
        REG_GRID_SIZE:   gs_r <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the grid side into 1..GRID_SIDE
  always_comb begin
    priority if (gs_r == '0) begin
      side_c = SIDE_W'(1);
    end else if (gs_r > SIDE_W'(GRID_SIDE)) begin
      side_c = SIDE_W'(GRID_SIDE);
    end else begin
      side_c = gs_r;
    end
  end

  assign cell_c = CELL_W'(tw_r) + CELL_W'({gw_r, 1'b0});

  // derived geometry, refreshed every cycle from the settings
  always_ff @(posedge clk) begin
    side_r <= side_c;
    cell_r <= cell_c;
    pat_r  <= PAT_W'(side_c) * PAT_W'(cell_c);
  end

  assign side_m1 = IDX_W'(side_r - SIDE_W'(1));

  // hold everything only while a result sits in the skid
  assign en        = !skid_valid_r;
  assign in_tready = en;

  tgh_wrap u_wrap_u (
    .clk      (clk),
    .en       (en),
    .coord    ($signed(in_tdata[31:0])),
    .pat      (pat_r),
    .cell_len (cell_r),
    .idx      (idx_u),
    .pos      (pos_u)
  );

  tgh_wrap u_wrap_v (
    .clk      (clk),
    .en       (en),
    .coord    ($signed(in_tdata[63:32])),
    .pat      (pat_r),
    .cell_len (cell_r),
    .idx      (idx_v),
    .pos      (pos_v)
  );

  // sideband travels alongside the wrap pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WRAP_LAT; k++) begin
        sb_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      sb_vld_r[0] <= in_tvalid;
      for (int k = 1; k < WRAP_LAT; k++) begin
        sb_vld_r[k] <= sb_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_op_r[0]    <= in_tuser[0];
      sb_waddr_r[0] <= {in_tdata[67:64], in_tdata[71:68]};
      sb_kind_r[0]  <= in_tdata[75:72];
      for (int k = 1; k < WRAP_LAT; k++) begin
        sb_op_r[k]    <= sb_op_r[k-1];
        sb_waddr_r[k] <= sb_waddr_r[k-1];
        sb_kind_r[k]  <= sb_kind_r[k-1];
      end
    end
  end

  // grout band direction per axis; low band includes the boundary itself
  assign hi_edge = CELL_W'(tw_r) + CELL_W'(gw_r);
  assign lo_u    = (pos_u <= CELL_W'(gw_r));
  assign hi_u    = (pos_u > hi_edge);
  assign lo_v    = (pos_v <= CELL_W'(gw_r));
  assign hi_v    = (pos_v > hi_edge);

  // neighbor index wraps around the grid side
  always_comb begin
    priority if (lo_u) begin
      nb_u = (idx_u == '0) ? side_m1 : idx_u - IDX_W'(1);
    end else if (hi_u) begin
      nb_u = (idx_u == side_m1) ? '0 : idx_u + IDX_W'(1);
    end else begin
      nb_u = idx_u;
    end
    priority if (lo_v) begin
      nb_v = (idx_v == '0) ? side_m1 : idx_v - IDX_W'(1);
    end else if (hi_v) begin
      nb_v = (idx_v == side_m1) ? '0 : idx_v + IDX_W'(1);
    end else begin
      nb_v = idx_v;
    end
  end

  // writes and reads share one stage, so request order is the access order
  always_comb begin
    greq.wr        = sb_vld_r[WRAP_LAT-1] && (sb_op_r[WRAP_LAT-1] == OP_WRITE);
    greq.waddr     = sb_waddr_r[WRAP_LAT-1];
    greq.wkind     = sb_kind_r[WRAP_LAT-1];
    greq.raddr_own = {idx_u, idx_v};
    greq.raddr_nb  = {nb_u, nb_v};
  end

  tgh_grid u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .req      (greq),
    .own_kind (own_kind),
    .nb_kind  (nb_kind)
  );

  tgh_bevel u_bevel_u (
    .clk   (clk),
    .en    (en),
    .pos   (pos_u),
    .tw    (tw_r),
    .gw    (gw_r),
    .bevel (bevel_u)
  );

  tgh_bevel u_bevel_v (
    .clk   (clk),
    .en    (en),
    .pos   (pos_v),
    .tw    (tw_r),
    .gw    (gw_r),
    .bevel (bevel_v)
  );

  // second half: wait for the bevel pipes, fold in the type compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BEVEL_LAT; k++) begin
        md_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      md_vld_r[0] <= sb_vld_r[WRAP_LAT-1];
      for (int k = 1; k < BEVEL_LAT; k++) begin
        md_vld_r[k] <= md_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_smp_r[0] <= (sb_op_r[WRAP_LAT-1] == OP_SAMPLE);
      edge_r      <= lo_u || hi_u || lo_v || hi_v;
      mix_r[1]    <= edge_r && (own_kind != nb_kind);
      for (int k = 1; k < BEVEL_LAT; k++) begin
        md_smp_r[k] <= md_smp_r[k-1];
      end
      for (int k = 2; k < BEVEL_LAT; k++) begin
        mix_r[k] <= mix_r[k-1];
      end
    end
  end

  // a zero cell width answers flat height
  assign hprod      = bevel_u * bevel_v;
  assign res_vld    = md_vld_r[BEVEL_LAT-1] && md_smp_r[BEVEL_LAT-1];
  assign res_mix    = mix_r[BEVEL_LAT-1] && (cell_r != '0);
  assign res_height = res_mix ? hprod[FRAC_BITS+HEIGHT_W-1:FRAC_BITS] : ONE_Q16;
  assign res_data   = {(OUT_DATA_W-HEIGHT_W-1)'(0), res_mix, res_height};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        // drain the skid into the output register
        if (out_tready) begin
          skid_valid_r <= 1'b0;
        end
      end else if (res_vld) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_vld) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end else begin
      out_data_r <= out_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TGH_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `TGH_ASSERT(a_skid_drains, skid_valid_r && out_tready |=> !skid_valid_r)
  `TGH_ASSERT(a_flat_without_grout, out_valid_r && !out_data_r[HEIGHT_W] |-> out_data_r[HEIGHT_W-1:0] == ONE_Q16)
  `TGH_ASSERT_NEVER(a_height_range, out_valid_r && (out_data_r[HEIGHT_W-1:0] > ONE_Q16))

endmodule

### hdl/tgh_wrap.sv
// Pipelined coordinate wrap: modulo over the pattern, then cell index and offset.
module tgh_wrap (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tgh_pkg::COORD_W-1:0]  coord,
  input  logic [tgh_pkg::PAT_W-1:0]           pat,
  input  logic [tgh_pkg::CELL_W-1:0]          cell_len,
  output logic [tgh_pkg::IDX_W-1:0]           idx,
  output logic [tgh_pkg::CELL_W-1:0]          pos
);
  import tgh_pkg::*;

  logic [COORD_W-1:0] c_bits;
  logic [PAT_W-1:0]   rem_r [0:COORD_W];
  logic [COORD_W-1:0] dvd_r [0:COORD_W-1];
  logic               neg_r [0:COORD_W];
  logic [PAT_W-1:0]   pu_r;
  logic [PAT_W-1:0]   qrem_r [0:IDX_W-1];
  logic [IDX_W-1:0]   q_r [0:IDX_W-1];

  assign c_bits = coord;

  // take the magnitude, fix the sign after the remainder chain
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dvd_r[0] <= c_bits[COORD_W-1] ? (~c_bits + 1'b1) : c_bits;
      neg_r[0] <= c_bits[COORD_W-1];
    end
  end

  for (genvar i = 0; i < COORD_W; i++) begin : g_mod
    logic [PAT_W:0] trial;
    assign trial = {rem_r[i], dvd_r[i][COORD_W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, pat}) begin
          rem_r[i+1] <= PAT_W'(trial - {1'b0, pat});
        end else begin
          rem_r[i+1] <= trial[PAT_W-1:0];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
    if (i < COORD_W - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[i+1] <= {dvd_r[i][COORD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[COORD_W] && (rem_r[COORD_W] != '0)) begin
        pu_r <= pat - rem_r[COORD_W];
      end else begin
        pu_r <= rem_r[COORD_W];
      end
    end
  end

  // cell index is below the grid side: one quotient bit per stage
  for (genvar j = 0; j < IDX_W; j++) begin : g_quo
    logic [PAT_W-1:0] src;
    logic [PAT_W-1:0] step;
    logic [IDX_W-1:0] qprev;
    logic             qbit;
    if (j == 0) begin : g_first
      assign src   = pu_r;
      assign qprev = '0;
    end else begin : g_next
      assign src   = qrem_r[j-1];
      assign qprev = q_r[j-1];
    end
    assign step = PAT_W'(cell_len) << (IDX_W - 1 - j);
    assign qbit = (src >= step);
    always_ff @(posedge clk) begin
      if (en) begin
        qrem_r[j] <= qbit ? (src - step) : src;
        q_r[j]    <= (qprev << 1) | IDX_W'(qbit);
      end
    end
  end

  assign idx = q_r[IDX_W-1];
  assign pos = qrem_r[IDX_W-1][CELL_W-1:0];

endmodule

### hdl/tgh_bevel.sv
// Pipelined per-axis bevel: grout ramp division and smoothstep.
module tgh_bevel (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tgh_pkg::CELL_W-1:0]    pos,
  input  logic [tgh_pkg::LEN_W-1:0]     tw,
  input  logic [tgh_pkg::LEN_W-1:0]     gw,
  output logic [tgh_pkg::HEIGHT_W-1:0]  bevel
);
  import tgh_pkg::*;

  logic [CELL_W-1:0]    hi_edge;
  logic                 lo_c;
  logic                 hi_c;
  logic [LEN_W-1:0]     rem_r [0:FRAC_BITS-1];
  logic [FRAC_BITS-1:0] q_r   [1:FRAC_BITS];
  logic                 lo_r  [0:FRAC_BITS];
  logic                 hi_r  [0:FRAC_BITS];
  logic [2*FRAC_BITS-1:0] sq;
  logic [FRAC_BITS-1:0] s_r;
  logic [FRAC_BITS-1:0] t_s_r;
  logic                 lo_s_r;
  logic                 hi_s_r;
  logic [FRAC_BITS+1:0] w;
  logic [2*FRAC_BITS+1:0] prod;
  logic [HEIGHT_W-1:0]  r_r;
  logic                 lo_rr;
  logic                 hi_rr;
  logic [HEIGHT_W-1:0]  bevel_r;

  // at most one ramp applies: rising near the low side, falling near the high side
  assign hi_edge = CELL_W'(tw) + CELL_W'(gw);
  assign lo_c    = (pos < CELL_W'(gw));
  assign hi_c    = (pos > hi_edge);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= lo_c ? pos[LEN_W-1:0] : LEN_W'(pos - hi_edge);
      lo_r[0]  <= lo_c;
      hi_r[0]  <= hi_c;
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [LEN_W:0]       trial;
    logic                 qbit;
    logic [FRAC_BITS-1:0] qprev;
    if (i == 0) begin : g_first
      assign qprev = '0;
    end else begin : g_next
      assign qprev = q_r[i];
    end
    assign trial = {rem_r[i], 1'b0};
    assign qbit  = (trial >= {1'b0, gw});
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]  <= {qprev[FRAC_BITS-2:0], qbit};
        lo_r[i+1] <= lo_r[i];
        hi_r[i+1] <= hi_r[i];
      end
    end
    if (i < FRAC_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= qbit ? LEN_W'(trial - {1'b0, gw}) : trial[LEN_W-1:0];
        end
      end
    end
  end

  assign sq = q_r[FRAC_BITS] * q_r[FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= sq[2*FRAC_BITS-1:FRAC_BITS];
      t_s_r  <= q_r[FRAC_BITS];
      lo_s_r <= lo_r[FRAC_BITS];
      hi_s_r <= hi_r[FRAC_BITS];
    end
  end

  assign w    = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(ONE_Q16) - (FRAC_BITS+2)'({t_s_r, 1'b0});
  assign prod = s_r * w;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= prod[FRAC_BITS+HEIGHT_W-1:FRAC_BITS];
      lo_rr <= lo_s_r;
      hi_rr <= hi_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (lo_rr) begin
        bevel_r <= r_r;
      end else if (hi_rr) begin
        bevel_r <= ONE_Q16 - r_r;
      end else begin
        bevel_r <= ONE_Q16;
      end
    end
  end

  assign bevel = bevel_r;

endmodule

### hdl/tgh_grid.sv
// Tile type grid memory: one write port, two registered read ports.
module tgh_grid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  tgh_pkg::grid_req_t              req,
  output logic [tgh_pkg::KIND_BITS-1:0]   own_kind,
  output logic [tgh_pkg::KIND_BITS-1:0]   nb_kind
);
  import tgh_pkg::*;

  logic [KIND_BITS-1:0]  mem [0:GRID_DEPTH-1];
  logic [GRID_DEPTH-1:0] vld_r;
  logic [KIND_BITS-1:0]  own_r;
  logic [KIND_BITS-1:0]  nb_r;
  logic                  own_v_r;
  logic                  nb_v_r;

  always_ff @(posedge clk) begin
    if (en && req.wr) begin
      mem[req.waddr] <= req.wkind;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en && req.wr) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      own_r   <= mem[req.raddr_own];
      nb_r    <= mem[req.raddr_nb];
      own_v_r <= vld_r[req.raddr_own];
      nb_v_r  <= vld_r[req.raddr_nb];
    end
  end

  assign own_kind = own_v_r ? own_r : '0;
  assign nb_kind  = nb_v_r ? nb_r : '0;

endmodule
